FILE: hdl/bloom_filter_double_hash_defines.svh
// ----------------------------------------------------------------------------
// bloom filter assertion macros
// shared property shapes for the bloom filter checks
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DOUBLE_HASH_DEFINES_SVH
`define BLOOM_FILTER_DOUBLE_HASH_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define BFDH_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("bfdh same-cycle check failed");

// condition holds in the cycle after the trigger
`define BFDH_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("bfdh next-cycle check failed");

`endif

FILE: hdl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg
// shared types and constants of the double-hash bloom filter
// ----------------------------------------------------------------------------
package bfdh_pkg;

   // default sizes
   localparam int MAX_WORDS_DEF  = 1024;
   localparam int MAX_PROBES_DEF = 16;

   // fixed field widths
   localparam int WORD_BITS   = 64;
   localparam int BIT_IDX_W   = 6;
   localparam int HALF_W      = 32;
   localparam int HASH_W      = 64;
   localparam int WC_W        = 11;
   localparam int PC_W        = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;

   // remainder unit: 4 dividend bits per step, 7 steps
   localparam int MOD_DIGITS  = 4;
   localparam int MOD_STEPS   = 7;
   localparam int MOD_DIV_W   = MOD_DIGITS * MOD_STEPS;
   localparam int MOD_STEP_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_COUNT = 2'd1;

   // register reset values
   localparam logic [WC_W-1:0] WORD_COUNT_RST  = 11'd1024;
   localparam logic [PC_W-1:0] PROBE_COUNT_RST = 5'd4;

   // commands
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // one probe handed to the bit store
   typedef struct packed {
      logic                 valid;
      logic                 add;
      logic [WC_W-1:0]      addr;
      logic [BIT_IDX_W-1:0] bit_idx;
   } probe_req_type;

   // bit store status back to the controller
   typedef struct packed {
      logic clearing;
      logic hit_valid;
      logic hit;
   } store_status_type;

endpackage

FILE: hdl/bloom_filter_double_hash.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// bloom filter over a store of 64-bit words with double-hash probing
// ----------------------------------------------------------------------------
// usage:
//   a word (req_cmd, req_hash) is taken at a clock edge with start high and
//   busy low. an add sets every probed bit and returns nothing; a query
//   returns one word on rsp_present, marked by a one-cycle rsp_valid pulse.
//   csr_we writes word_count (index 0) or probe_count (index 1) while idle.
// timing:
//   the word index of each probe comes from an incremental remainder; three
//   7-step remainder units (4 bits a step) prepare the start value, the step
//   and the wrap correction in the setup state, then one store read per probe
//   and a last check in the drain state follow.
//   busy stays high from the accepting edge through the drain state; a query's
//   rsp_valid pulse comes with busy low, so a new word is taken only once the
//   last one is through, one item at a time.
// reset:
//   reset clears the bit store in a sweep, one word per cycle, with busy held
//   high; configuration writes are taken meanwhile.
//   the receiver cannot stall: results are presented for exactly one cycle.
// ----------------------------------------------------------------------------
`include "bloom_filter_double_hash_defines.svh"

module bloom_filter_double_hash
   import bfdh_pkg::*;
#(
   parameter int MAX_WORDS  = MAX_WORDS_DEF,
   parameter int MAX_PROBES = MAX_PROBES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [HASH_W-1:0]     req_hash,
   output logic                  rsp_valid,
   output logic                  rsp_present,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   localparam logic [MOD_DIV_W-1:0] WRAP_DIVIDEND = MOD_DIV_W'(1) << (HALF_W - BIT_IDX_W);

   logic [1:0]        state_ff, state_in;
   logic [WC_W-1:0]   word_count_ff, word_count_in;
   logic [PC_W-1:0]   probe_count_ff, probe_count_in;
   logic              cmd_ff;
   logic [HALF_W-1:0] x_ff, x_in;
   logic [HALF_W-1:0] l_ff;
   logic [WC_W-1:0]   w_ff;
   logic [PC_W-1:0]   probes_ff;
   logic [PC_W-1:0]   cnt_ff, cnt_in;
   logic [WC_W-1:0]   r_ff, r_in;
   logic [WC_W-1:0]   step_ff;
   logic [WC_W-1:0]   wrap_ff;
   logic              present_ff, present_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_present_ff, rsp_present_in;

   logic              accept;
   logic [WC_W-1:0]   w_use;
   logic [PC_W-1:0]   p_use;
   logic              mod_done_h, mod_done_l, mod_done_w;
   logic [WC_W-1:0]   rem_h, rem_l, rem_w;
   logic              miss;
   logic [WC_W-1:0]   r_next;
   logic [HALF_W:0]   x_sum;
   logic [BIT_IDX_W:0] low_sum;

   probe_req_type     probe;
   store_status_type  status;

   // configuration registers
   always_comb begin
      word_count_in  = word_count_ff;
      probe_count_in = probe_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WORD_COUNT:  word_count_in  = csr_wdata[WC_W-1:0];
            CSR_PROBE_COUNT: probe_count_in = csr_wdata[PC_W-1:0];
            default: ;
         endcase
      end
   end

   // words and probes in use, clamped
   always_comb begin
      if (word_count_ff == '0) begin
         w_use = WC_W'(1);
      end else if (int'(word_count_ff) > MAX_WORDS) begin
         w_use = WC_W'(MAX_WORDS);
      end else begin
         w_use = word_count_ff;
      end
      if (int'(probe_count_ff) > MAX_PROBES) begin
         p_use = PC_W'(MAX_PROBES);
      end else begin
         p_use = probe_count_ff;
      end
   end

   assign busy   = (state_ff != ST_IDLE) || status.clearing;
   assign accept = start && !busy;

   // remainder units: start word, step and 2^26 wrap correction
   bfdh_mod_unit u_mod_high (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (MOD_DIV_W'(req_hash[HASH_W-1:HALF_W+BIT_IDX_W])),
      .divisor  (w_use),
      .done     (mod_done_h),
      .rem      (rem_h)
   );

   bfdh_mod_unit u_mod_low (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (MOD_DIV_W'(req_hash[HALF_W-1:BIT_IDX_W])),
      .divisor  (w_use),
      .done     (mod_done_l),
      .rem      (rem_l)
   );

   bfdh_mod_unit u_mod_wrap (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (WRAP_DIVIDEND),
      .divisor  (w_use),
      .done     (mod_done_w),
      .rem      (rem_w)
   );

   // next probe position: 32-bit sum, word index stepped modulo the word count
   always_comb begin
      logic [WC_W:0] s;
      x_sum   = {1'b0, x_ff} + {1'b0, l_ff};
      low_sum = {1'b0, x_ff[BIT_IDX_W-1:0]} + {1'b0, l_ff[BIT_IDX_W-1:0]};
      s = {1'b0, r_ff} + {1'b0, step_ff} + (WC_W+1)'(low_sum[BIT_IDX_W]);
      if (s >= {1'b0, w_ff}) begin
         s = s - {1'b0, w_ff};
      end
      if (x_sum[HALF_W]) begin
         if (s >= {1'b0, wrap_ff}) begin
            s = s - {1'b0, wrap_ff};
         end else begin
            s = s + {1'b0, w_ff} - {1'b0, wrap_ff};
         end
      end
      r_next = s[WC_W-1:0];
   end

   // probe to the store
   assign probe.valid   = (state_ff == ST_PROBE);
   assign probe.add     = (cmd_ff == CMD_ADD);
   assign probe.addr    = r_ff;
   assign probe.bit_idx = x_ff[BIT_IDX_W-1:0];

   bfdh_bit_store #(
      .MAX_WORDS (MAX_WORDS)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .probe  (probe),
      .status (status)
   );

   assign miss = status.hit_valid && !status.hit;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      x_in           = x_ff;
      r_in           = r_ff;
      present_in     = present_ff && !miss;
      rsp_valid_in   = 1'b0;
      rsp_present_in = rsp_present_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_SETUP;
               x_in       = req_hash[HASH_W-1:HALF_W];
               present_in = 1'b1;
            end
         end
         ST_SETUP: begin
            if (mod_done_h && mod_done_l && mod_done_w) begin
               r_in   = rem_h;
               cnt_in = '0;
               if (probes_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            x_in   = x_sum[HALF_W-1:0];
            r_in   = r_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == probes_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in       = ST_IDLE;
            rsp_valid_in   = (cmd_ff == CMD_QUERY);
            rsp_present_in = present_ff && !miss;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         word_count_ff  <= WORD_COUNT_RST;
         probe_count_ff <= PROBE_COUNT_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         word_count_ff  <= word_count_in;
         probe_count_ff <= probe_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         l_ff      <= req_hash[HALF_W-1:0];
         w_ff      <= w_use;
         probes_ff <= p_use;
      end
      if (state_ff == ST_SETUP) begin
         step_ff <= rem_l;
         wrap_ff <= rem_w;
      end
      x_ff           <= x_in;
      r_ff           <= r_in;
      cnt_ff         <= cnt_in;
      present_ff     <= present_in;
      rsp_present_ff <= rsp_present_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;

   // checks
   `BFDH_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `BFDH_ASSERT_SAME(a_rsp_query, clock, reset, rsp_valid, cmd_ff == CMD_QUERY)
   `BFDH_ASSERT_SAME(a_clear_busy, clock, reset, status.clearing, busy && !probe.valid)
   `BFDH_ASSERT_NEXT(a_accept_setup, clock, reset, accept, state_ff == ST_SETUP)

endmodule

FILE: hdl/bfdh_mod_unit.sv
// ----------------------------------------------------------------------------
// bfdh_mod_unit
// iterative remainder of a 28-bit dividend by an 11-bit divisor, 4 bits a step
// ----------------------------------------------------------------------------
module bfdh_mod_unit
   import bfdh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MOD_DIV_W-1:0] dividend,
   input  logic [WC_W-1:0]      divisor,
   output logic                 done,
   output logic [WC_W-1:0]      rem
);

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic [MOD_DIV_W-1:0]  quo_ff, quo_in;
   logic [WC_W-1:0]       rem_ff, rem_in;
   logic [WC_W-1:0]       rem_step;

   // four restoring remainder steps on narrow values
   always_comb begin
      logic [WC_W:0] t;
      logic [WC_W-1:0] r;
      r = rem_ff;
      for (int k = 0; k < MOD_DIGITS; k++) begin
         t = {r, quo_ff[MOD_DIV_W-1-k]};
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
         end
         r = t[WC_W-1:0];
      end
      rem_step = r;
   end

   // step sequencing
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         quo_in    = dividend;
         rem_in    = '0;
      end else if (active_ff) begin
         quo_in  = quo_ff << MOD_DIGITS;
         rem_in  = rem_step;
         step_in = step_ff + 1'b1;
         if (step_ff == MOD_STEP_W'(MOD_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: hdl/bfdh_bit_store.sv
// ----------------------------------------------------------------------------
// bfdh_bit_store
// bit store memory with read-modify-write, write forwarding and reset clearing
// ----------------------------------------------------------------------------
module bfdh_bit_store
   import bfdh_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  probe_req_type    probe,
   output store_status_type status
);

   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic [WORD_BITS-1:0] store_mem [MAX_WORDS];

   logic                 clr_active_ff, clr_active_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 s1_valid_ff;
   logic                 s1_add_ff;
   logic [AW-1:0]        s1_addr_ff;
   logic [BIT_IDX_W-1:0] s1_bit_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 fwd_valid_ff;
   logic [AW-1:0]        fwd_addr_ff;
   logic [WORD_BITS-1:0] fwd_data_ff;
   logic [WORD_BITS-1:0] cur_word;
   logic [WORD_BITS-1:0] wr_word;
   logic                 wr_en;

   // clearing sweep after reset
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(MAX_WORDS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= probe.valid;
         fwd_valid_ff  <= wr_en;
      end
   end

   // probe stage payload
   always_ff @(posedge clock) begin
      s1_add_ff   <= probe.add;
      s1_addr_ff  <= AW'(probe.addr);
      s1_bit_ff   <= probe.bit_idx;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= wr_word;
   end

   // word seen by the probe, taking a write of the previous cycle
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur_word = fwd_data_ff;
      end else begin
         cur_word = rd_data_ff;
      end
      wr_word = cur_word | (WORD_BITS'(1) << s1_bit_ff);
      wr_en   = s1_valid_ff && s1_add_ff;
   end

   // memory read port
   always_ff @(posedge clock) begin
      if (probe.valid) begin
         rd_data_ff <= store_mem[AW'(probe.addr)];
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         store_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         store_mem[s1_addr_ff] <= wr_word;
      end
   end

   assign status.clearing  = clr_active_ff;
   assign status.hit_valid = s1_valid_ff;
   assign status.hit       = cur_word[s1_bit_ff];

endmodule

FILE: verif/tb_bloom_filter_double_hash.sv
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash
// self-checking bench for the double-hash bloom filter: a directed table of
// corner hashes, then phases of random adds and queries over several store
// and probe settings, queries checked on fixed answers or an in-bench filter
// ----------------------------------------------------------------------------
module tb_bloom_filter_double_hash;
   import bfdh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WORDS    = MAX_WORDS_DEF;
   localparam int MAX_PROBES   = MAX_PROBES_DEF;
   localparam int WIDX_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int PHASE_ITEMS  = 115;
   localparam int NUM_PHASES   = 11;
   localparam int DRAIN_CYCLES = 64;
   localparam int LIMIT_CYCLES = 400000;
   localparam int KEY_MEMORY   = 48;

   // one row of the directed table; fixed rows carry a known answer
   typedef struct packed {
      logic        cmd;
      logic [63:0] hash;
      logic        fixed;
      logic        fixed_present;
   } dir_row_type;

   localparam int NUM_DIR = 18;
   localparam dir_row_type DIRECTED [NUM_DIR] = '{
      '{CMD_QUERY, 64'h0000_0000_0000_0000, 1'b1, 1'b0},
      '{CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
      '{CMD_ADD,   64'h0000_0000_0000_0000, 1'b0, 1'b0},
      '{CMD_QUERY, 64'h0000_0000_0000_0000, 1'b1, 1'b1},
      '{CMD_QUERY, 64'h0000_0000_0000_0001, 1'b1, 1'b0},
      '{CMD_ADD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
      '{CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
      '{CMD_ADD,   64'h8000_0000_0000_0001, 1'b0, 1'b0},
      '{CMD_QUERY, 64'h8000_0000_0000_0001, 1'b1, 1'b1},
      '{CMD_QUERY, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
      '{CMD_ADD,   64'h0000_0001_FFFF_FFFF, 1'b0, 1'b0},
      '{CMD_QUERY, 64'h0000_0001_FFFF_FFFF, 1'b1, 1'b1},
      '{CMD_QUERY, 64'h0000_0001_0000_0000, 1'b0, 1'b0},
      '{CMD_ADD,   64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b0},
      '{CMD_QUERY, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 1'b1},
      '{CMD_ADD,   64'h5A5A_A5A5_F0F0_0F0F, 1'b0, 1'b0},
      '{CMD_QUERY, 64'h5A5A_A5A5_F0F0_0F0E, 1'b0, 1'b0},
      '{CMD_QUERY, 64'h0000_FFFF_0000_0040, 1'b0, 1'b0}
   };

   // register settings per random phase: extremes, zero and oversize values
   localparam logic [CSR_DATA_W-1:0] PHASE_WORDS [NUM_PHASES] = '{
      11'd1, 11'd1, 11'd0, 11'd2047, 11'd5, 11'd3, 11'd1024, 11'd2, 11'd17,
      11'd64, 11'd1024
   };
   localparam logic [CSR_DATA_W-1:0] PHASE_PROBES [NUM_PHASES] = '{
      11'd1, 11'd16, 11'd4, 11'd16, 11'd0, 11'd31, 11'd7, 11'd2, 11'd5,
      11'h7E3, 11'd4
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   logic                  req_cmd     = CMD_ADD;
   logic [HASH_W-1:0]     req_hash    = '0;
   logic                  rsp_valid;
   logic                  rsp_present;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_WORD_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // in-bench copy of the filter state and settings
   logic [63:0]     filter_bits [MAX_WORDS];
   logic [WC_W-1:0] words_cfg;
   logic [PC_W-1:0] probes_cfg;

   logic        present_q [$];
   logic [63:0] added_keys [$];
   logic        want_present;
   int          errors      = 0;
   int          cycle_count = 0;
   int          burst_left  = 0;

   bloom_filter_double_hash u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .req_hash    (req_hash),
      .rsp_valid   (rsp_valid),
      .rsp_present (rsp_present),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // apply one add or query to the filter copy; returns the all-set flag
   function automatic logic bloom_lookup(input logic cmd, input logic [63:0] hash);
      logic [31:0]       hi;
      logic [31:0]       lo;
      logic [31:0]       pos;
      logic [31:0]       total;
      logic [WIDX_W-1:0] word_idx;
      int unsigned       words;
      int unsigned       probes;
      logic              all_set;
      hi      = hash[63:32];
      lo      = hash[31:0];
      words   = 32'(words_cfg);
      probes  = 32'(probes_cfg);
      // zero words means one, oversize saturates
      if (words == 0) words = 1;
      if (words > MAX_WORDS) words = MAX_WORDS;
      if (probes > MAX_PROBES) probes = MAX_PROBES;
      total   = 32'(words * 64);
      all_set = 1'b1;
      for (int i = 0; i < probes; i++) begin
         pos      = hi + 32'(i) * lo;
         pos      = pos % total;
         word_idx = WIDX_W'(pos / 64);
         if (cmd == CMD_ADD) begin
            filter_bits[word_idx][pos[5:0]] = 1'b1;
         end else if (!filter_bits[word_idx][pos[5:0]]) begin
            all_set = 1'b0;
            break;
         end
      end
      return all_set;
   endfunction

   // random hash with a bias toward extreme halves
   function automatic logic [63:0] random_hash();
      case ($urandom_range(0, 9))
         0: return {32'hFFFF_FFFF, 32'($urandom)};
         1: return {32'($urandom), 32'h0000_0000};
         2: return {32'($urandom), 32'hFFFF_FFFF};
         3: return {32'h0000_0000, 32'($urandom)};
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   // idle length after a word: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one word until taken, then update the filter copy
   task automatic send_word(input logic cmd, input logic [63:0] hash,
                            input logic fixed, input logic fixed_present);
      logic got;
      start    <= 1'b1;
      req_cmd  <= cmd;
      req_hash <= hash;
      @(posedge clock);
      while (busy) @(posedge clock);
      got = bloom_lookup(cmd, hash);
      if (cmd == CMD_QUERY) begin
         present_q.insert(present_q.size(), fixed ? fixed_present : got);
      end else begin
         added_keys.insert(added_keys.size(), hash);
         if (added_keys.size() > KEY_MEMORY) void'(added_keys.pop_front());
      end
   endtask

   // idle between words, with occasional back-to-back bursts
   task automatic idle_after_word();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 29) == 0) burst_left = 20;
         gap = pick_gap();
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for all answers, let trailing adds finish, then for busy low
   task automatic wait_quiet();
      while (present_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // write both registers back to back
   task automatic configure(input logic [CSR_DATA_W-1:0] wc,
                            input logic [CSR_DATA_W-1:0] pc);
      csr_we    <= 1'b1;
      csr_index <= CSR_WORD_COUNT;
      csr_wdata <= wc;
      @(posedge clock);
      words_cfg  = wc[WC_W-1:0];
      csr_index <= CSR_PROBE_COUNT;
      csr_wdata <= pc;
      @(posedge clock);
      probes_cfg = pc[PC_W-1:0];
      csr_we    <= 1'b0;
   endtask

   // result checker: every strobe pops the oldest expected word
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (present_q.size() == 0) begin
            $error("unexpected word: present actual %0b", rsp_present);
            errors++;
         end else begin
            want_present = present_q.pop_front();
            if (rsp_present !== want_present) begin
               $error("present mismatch: expected %0b, actual %0b",
                      want_present, rsp_present);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic        cmd;
      logic [63:0] hash;
      int          r;
      for (int w = 0; w < MAX_WORDS; w++) filter_bits[w] = '0;
      words_cfg  = WORD_COUNT_RST;
      probes_cfg = PROBE_COUNT_RST;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // store clearing sweep
      while (busy) @(posedge clock);

      // directed table under reset settings
      for (int k = 0; k < NUM_DIR; k++) begin
         send_word(DIRECTED[k].cmd, DIRECTED[k].hash,
                   DIRECTED[k].fixed, DIRECTED[k].fixed_present);
         idle_after_word();
      end
      start <= 1'b0;

      // random phases, each under its own settings
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_quiet();
         configure(PHASE_WORDS[ph], PHASE_PROBES[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45 || added_keys.size() == 0) begin
               // new key, or a random query before any key exists
               cmd  = (r < 45) ? CMD_ADD : CMD_QUERY;
               hash = random_hash();
            end else if (r < 85) begin
               // query a key added earlier
               cmd  = CMD_QUERY;
               hash = added_keys[$urandom_range(0, added_keys.size() - 1)];
            end else if (r < 93) begin
               // near miss: one bit off a known key
               cmd  = CMD_QUERY;
               hash = added_keys[$urandom_range(0, added_keys.size() - 1)];
               hash[$urandom_range(0, 63)] ^= 1'b1;
            end else begin
               cmd  = CMD_QUERY;
               hash = random_hash();
            end
            send_word(cmd, hash, 1'b0, 1'b0);
            idle_after_word();
         end
         start <= 1'b0;
      end

      // drain and close
      while (present_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && present_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
